FILE: rtl/tte_pkg.sv
package tte_pkg;

  localparam int unsigned TsW   = 32;
  localparam int unsigned BpmW  = 26;
  localparam int unsigned SumW  = 34;
  localparam int unsigned StepW = 6;

  localparam logic [BpmW-1:0]  BpmNumerator = 26'd60000000;
  localparam logic [StepW-1:0] BpmSteps     = 6'd26;
  // The integer part of 2^32 / 3, and the reciprocal of 3 scaled by 2^33 and rounded up.
  localparam logic [TsW-1:0]   ThirdOfWrap  = 32'h5555_5555;
  localparam logic [TsW-1:0]   RecipThree   = 32'hAAAA_AAAB;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD3,
    ST_RD2,
    ST_RD1,
    ST_RD0,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_C,
    ST_AVG_FOLD,
    ST_AVG_MUL,
    ST_AVG_TAKE,
    ST_DECIDE,
    ST_BPM_GO,
    ST_BPM_WAIT,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {RD_NONE, RD_OFF3, RD_OFF2, RD_OFF1} rd_e;
  typedef enum logic [1:0] {CAP_NONE, CAP_A2, CAP_A1, CAP_A0} cap_e;
  typedef enum logic [1:0] {CMP_NONE, CMP_A1_A0, CMP_A2_A0, CMP_A0_A2} cmp_e;
  typedef enum logic [1:0] {AVG_NONE, AVG_FOLD, AVG_MUL, AVG_TAKE} avg_e;
  typedef enum logic {DIV_NONE, DIV_BPM} div_e;

  typedef struct packed {
    logic load;
    logic store;
    rd_e  rd;
    cap_e cap;
    cmp_e cmp;
    avg_e avg;
    div_e div;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic div_busy;
    logic div_done;
    logic good;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/tte_div.sv
module tte_div
  import tte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  dividend_i,
  input  logic [TsW-1:0]   divisor_i,
  input  logic [StepW-1:0] steps_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [SumW-1:0]  quotient_o
);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [TsW-1:0]   rem_q;
  logic [TsW-1:0]   den_q;
  logic [SumW-1:0]  nq_q;
  logic [TsW:0]     rem_sh;
  logic [TsW:0]     diff;
  logic             ge;

  // One quotient bit per cycle; dividend bits shift out of the top of nq_q as
  // quotient bits shift in at the bottom.
  assign rem_sh = {rem_q, nq_q[SumW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= divisor_i;
      nq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TsW-1:0] : rem_sh[TsW-1:0];
      nq_q  <= {nq_q[SumW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = nq_q;

endmodule

FILE: rtl/tte_datapath.sv
module tte_datapath
  import tte_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            channel_i,
  input  logic [TsW-1:0]  timestamp_i,
  input  cmd_t            cmd_i,
  output status_t         status_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            channel_o,
  output logic            accepted_o,
  output logic            updated_o,
  output logic [BpmW-1:0] bpm_o,
  output logic [TsW-1:0]  interval_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int Depth  = CHANNELS * 4;
  localparam int AddrW  = $clog2(Depth);

  logic              ch_q;
  logic [TsW-1:0]    ts_q;
  logic [1:0]        p_q;
  logic [TsW-1:0]    prev_q  [CHANNELS];
  logic [1:0]        wptr_q  [CHANNELS];
  logic [BpmW-1:0]   bpm_q   [CHANNELS];
  logic [TsW-1:0]    intv_q  [CHANNELS];
  logic [TsW-1:0]    hist_mem [Depth];
  logic [Depth-1:0]  hv_q;
  logic [TsW-1:0]    rd_data_q;
  logic              rd_vld_q;
  logic [TsW-1:0]    tl_q;
  logic [TsW-1:0]    a0_q;
  logic [TsW-1:0]    a1_q;
  logic [TsW-1:0]    a2_q;
  logic [SumW-1:0]   sum_q;
  logic [TsW-1:0]    third_z_q;
  logic [TsW-1:0]    third_hi_q;
  logic [2*TsW-1:0]  third_prod_q;
  logic [TsW-1:0]    avg_q;
  logic              agree_q;
  logic              acc_q;
  logic              upd_q;
  logic              out_valid_q;
  logic              o_ch_q;
  logic              o_acc_q;
  logic              o_upd_q;
  logic [BpmW-1:0]   o_bpm_q;
  logic [TsW-1:0]    o_intv_q;

  logic [ChIdxW-1:0] ch_idx;
  logic              in_range;
  logic [1:0]        rd_ptr;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic [TsW-1:0]    rd_val;
  logic [TsW-1:0]    diff;
  logic [TsW-1:0]    lhs;
  logic [TsW-1:0]    rhs;
  logic              lt;
  logic [TsW:0]      fold_y;
  logic [TsW-1:0]    fold_z;
  logic [1:0]        fold_n;
  logic [TsW-1:0]    fold_hi;
  logic              div_start;
  logic [SumW-1:0]   div_dividend;
  logic [TsW-1:0]    div_divisor;
  logic [StepW-1:0]  div_steps;
  logic              div_busy;
  logic              div_done;
  logic [SumW-1:0]   quotient;
  logic              out_free;

  assign ch_idx   = ChIdxW'(ch_q);
  assign in_range = ({31'd0, ch_q} < 32'(CHANNELS));
  assign wr_addr  = AddrW'({ch_idx, wptr_q[ch_idx]});
  assign rd_addr  = AddrW'({ch_idx, rd_ptr});
  assign rd_val   = rd_vld_q ? rd_data_q : '0;
  assign diff     = ((cmd_i.cap == CAP_A2) ? ts_q : tl_q) - rd_val;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.rd)
      RD_OFF3: rd_ptr = p_q + 2'd3;
      RD_OFF2: rd_ptr = p_q + 2'd2;
      RD_OFF1: rd_ptr = p_q + 2'd1;
      default: rd_ptr = p_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cmp)
      CMP_A1_A0: begin
        lhs = a1_q;
        rhs = a0_q;
      end
      CMP_A2_A0: begin
        lhs = a2_q;
        rhs = a0_q;
      end
      default: begin
        lhs = a0_q;
        rhs = a2_q;
      end
    endcase
  end

  // Exact test of 4 * lhs < 5 * rhs.
  assign lt = ({1'b0, lhs, 2'b00} < ({1'b0, rhs, 2'b00} + (TsW + 3)'(rhs)));

  // Each wrap of 2^32 in the sum is worth a third of the wrap and leaves one over, so the
  // upper bits fold twice into a 32-bit remainder that the reciprocal then divides.
  assign fold_y = {1'b0, sum_q[TsW-1:0]} + (TsW + 1)'(sum_q[SumW-1:TsW]);
  assign fold_z = fold_y[TsW-1:0] + TsW'(fold_y[TsW]);
  assign fold_n = sum_q[SumW-1:TsW] + {1'b0, fold_y[TsW]};

  always_comb begin
    case (fold_n)
      2'd1:    fold_hi = ThirdOfWrap;
      2'd2:    fold_hi = {ThirdOfWrap[TsW-2:0], 1'b0};
      default: fold_hi = '0;
    endcase
  end

  assign div_start    = (cmd_i.div == DIV_BPM);
  assign div_dividend = {BpmNumerator, {(SumW - BpmW){1'b0}}};
  assign div_divisor  = avg_q;
  assign div_steps    = BpmSteps;

  tte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      hist_mem[wr_addr] <= ts_q;
    end
    if (cmd_i.rd != RD_NONE) begin
      rd_data_q <= hist_mem[rd_addr];
      rd_vld_q  <= hv_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_q[i] <= '0;
        wptr_q[i] <= '0;
        bpm_q[i]  <= '0;
        intv_q[i] <= '0;
      end
      agree_q     <= 1'b0;
      acc_q       <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        agree_q <= 1'b1;
        acc_q   <= 1'b0;
        upd_q   <= 1'b0;
      end
      if (cmd_i.store) begin
        hv_q[wr_addr]  <= 1'b1;
        prev_q[ch_idx] <= ts_q;
        wptr_q[ch_idx] <= wptr_q[ch_idx] + 2'd1;
        acc_q          <= 1'b1;
      end
      if (cmd_i.cmp != CMP_NONE) begin
        agree_q <= agree_q & lt;
      end
      if (cmd_i.commit) begin
        bpm_q[ch_idx]  <= quotient[BpmW-1:0];
        intv_q[ch_idx] <= avg_q;
        upd_q          <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= channel_i;
      ts_q  <= timestamp_i;
      sum_q <= '0;
    end
    if (cmd_i.store) begin
      p_q <= wptr_q[ch_idx];
    end
    if (cmd_i.cap != CAP_NONE) begin
      tl_q  <= rd_val;
      sum_q <= sum_q + SumW'(diff);
    end
    case (cmd_i.cap)
      CAP_A2:  a2_q <= diff;
      CAP_A1:  a1_q <= diff;
      CAP_A0:  a0_q <= diff;
      default: ;
    endcase
    case (cmd_i.avg)
      AVG_FOLD: begin
        third_z_q  <= fold_z;
        third_hi_q <= fold_hi;
      end
      AVG_MUL: begin
        third_prod_q <= (2 * TsW)'(third_z_q) * (2 * TsW)'(RecipThree);
      end
      AVG_TAKE: begin
        avg_q <= third_hi_q + {1'b0, third_prod_q[2*TsW-1:TsW+1]};
      end
      default: ;
    endcase
    if (cmd_i.emit) begin
      o_ch_q   <= ch_q;
      o_acc_q  <= acc_q;
      o_upd_q  <= upd_q;
      o_bpm_q  <= in_range ? bpm_q[ch_idx] : '0;
      o_intv_q <= in_range ? intv_q[ch_idx] : '0;
    end
  end

  assign status_o.take     = in_range && (ts_q != prev_q[ch_idx]);
  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;
  assign status_o.good     = agree_q && (avg_q != '0);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign channel_o   = o_ch_q;
  assign accepted_o  = o_acc_q;
  assign updated_o   = o_upd_q;
  assign bpm_o       = o_bpm_q;
  assign interval_o  = o_intv_q;

endmodule

FILE: rtl/tte_ctrl.sv
module tte_ctrl
  import tte_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.take) begin
          cmd_o.store = 1'b1;
          state_d     = ST_RD3;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RD3: begin
        cmd_o.rd = RD_OFF3;
        state_d  = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd  = RD_OFF2;
        cmd_o.cap = CAP_A2;
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd  = RD_OFF1;
        cmd_o.cap = CAP_A1;
        state_d   = ST_RD0;
      end
      ST_RD0: begin
        cmd_o.cap = CAP_A0;
        state_d   = ST_CMP_A;
      end
      ST_CMP_A: begin
        cmd_o.cmp = CMP_A1_A0;
        state_d   = ST_CMP_B;
      end
      ST_CMP_B: begin
        cmd_o.cmp = CMP_A2_A0;
        state_d   = ST_CMP_C;
      end
      ST_CMP_C: begin
        cmd_o.cmp = CMP_A0_A2;
        state_d   = ST_AVG_FOLD;
      end
      ST_AVG_FOLD: begin
        cmd_o.avg = AVG_FOLD;
        state_d   = ST_AVG_MUL;
      end
      ST_AVG_MUL: begin
        cmd_o.avg = AVG_MUL;
        state_d   = ST_AVG_TAKE;
      end
      ST_AVG_TAKE: begin
        cmd_o.avg = AVG_TAKE;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = status_i.good ? ST_BPM_GO : ST_RESULT;
      end
      ST_BPM_GO: begin
        cmd_o.div = DIV_BPM;
        state_d   = ST_BPM_WAIT;
      end
      ST_BPM_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/tap_tempo_bpm_estimator.sv
// Channel   Direction  tdata                                   tuser
// s_axis    in         [31:0] timestamp                        [0] channel
// m_axis    out        [25:0] beats_per_minute,                [0] channel_out,
//                      [57:26] beat_interval, [63:58] zero     [1] tap_accepted,
//                                                              [2] estimate_updated
//
// One tap is handled at a time. A repeated or out-of-range tap skips the history, a stored
// tap whose intervals disagree skips the divider, and one that updates the estimate waits
// on the serial divider for the tempo, which takes one quotient bit per cycle over 26 bits.
// The history memory is read one entry a cycle and the average is taken by a reciprocal
// multiplication in fold, multiply and take steps.
// Reset clears all history, pointers and held estimates at once.
// A stalled result waits in the output register while the next tap is worked on.
module tap_tempo_bpm_estimator
  import tte_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // timestamp
  input  logic [0:0]  s_axis_tuser,  // channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // beats_per_minute, beat_interval, zero fill
  output logic [2:0]  m_axis_tuser   // channel_out, tap_accepted, estimate_updated
);

  cmd_t            cmd;
  status_t         status;
  logic            out_ch;
  logic            out_acc;
  logic            out_upd;
  logic [BpmW-1:0] out_bpm;
  logic [TsW-1:0]  out_intv;

  tte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tte_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .channel_i   (s_axis_tuser[0]),
    .timestamp_i (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .channel_o   (out_ch),
    .accepted_o  (out_acc),
    .updated_o   (out_upd),
    .bpm_o       (out_bpm),
    .interval_o  (out_intv)
  );

  assign m_axis_tdata = {6'd0, out_intv, out_bpm};
  assign m_axis_tuser = {out_upd, out_acc, out_ch};

  a_upd_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
    else $error("estimate updated without a stored tap");

  a_upd_nonzero_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[57:26] != 32'd0)
    else $error("estimate updated with a zero interval");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div != DIV_NONE |-> !status.div_busy)
    else $error("divider started while busy");

  a_one_tap_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second tap taken while one is at work");

endmodule
